### hw/rtl/palette_pixel_run_to_lcd_bus_unit_defines.svh
// Assertion macros shared by the palette pixel run to LCD bus unit.
`ifndef PALETTE_PIXEL_RUN_TO_LCD_BUS_UNIT_DEFINES_SVH
`define PALETTE_PIXEL_RUN_TO_LCD_BUS_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PPLCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PPLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pplcd_pkg.sv
// Shared types, constants, microcode table and helpers of the LCD bus unit.
package pplcd_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int COORD_BITS    = 11;

    localparam int PAL_AW    = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);
    localparam logic [10:0] COORD_MASK = 11'((32'd1 << COORD_BITS) - 32'd1);
    localparam logic [10:0] END_COL_RST = 11'd319;

    localparam int IN_TDATA_W  = 80;
    localparam int APB_AW      = 3;
    localparam logic [APB_AW-1:0] REG_END_COL = 3'd0;

    // display commands
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_PASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    typedef enum logic [1:0] {
        MODE_PAL_WR = 2'd0,
        MODE_START  = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_RSVD   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        DEPTH_1BPP = 2'd0,
        DEPTH_4BPP = 2'd1,
        DEPTH_8BPP = 2'd2,
        DEPTH_RSVD = 2'd3
    } t_depth;

    typedef enum logic [3:0] {
        SRC_NONE, SRC_CASET, SRC_PASET, SRC_RAMWR,
        SRC_X_HI, SRC_X_LO, SRC_E_HI, SRC_E_LO, SRC_Y_HI, SRC_Y_LO,
        SRC_PIX0, SRC_PIX1, SRC_PIX2
    } t_src;

    typedef enum logic [1:0] {
        LAST_NO, LAST_YES, LAST_PIX
    } t_lastk;

    typedef enum logic [2:0] {
        JMP_NEXT, JMP_DISPATCH, JMP_PTEST, JMP_PLOOP, JMP_IDLE
    } t_jmp;

    typedef logic [3:0] t_step;

    localparam t_step ST_IDLE  = 4'd0;
    localparam t_step ST_CASET = 4'd1;
    localparam t_step ST_XH    = 4'd2;
    localparam t_step ST_XL    = 4'd3;
    localparam t_step ST_EH    = 4'd4;
    localparam t_step ST_EL    = 4'd5;
    localparam t_step ST_PASET = 4'd6;
    localparam t_step ST_YH0   = 4'd7;
    localparam t_step ST_YL0   = 4'd8;
    localparam t_step ST_YH1   = 4'd9;
    localparam t_step ST_YL1   = 4'd10;
    localparam t_step ST_RAMWR = 4'd11;
    localparam t_step ST_PTEST = 4'd12;
    localparam t_step ST_PIX0  = 4'd13;
    localparam t_step ST_PIX1  = 4'd14;
    localparam t_step ST_PIX2  = 4'd15;

    typedef struct packed {
        logic   emit;
        t_src   src;
        logic   is_data;
        t_lastk lastk;
        t_jmp   jmp;
        logic   rd;
        logic   adv;
    } t_cw;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic  in_fire;
        t_mode mode;
        logic  pix_ok;
        logic  next_ok;
        logic  out_free;
    } t_cond;

    // sequencer outputs to the datapath
    typedef struct packed {
        t_cw  cw;
        logic fire;
        logic done;
        logic idle;
    } t_ctl;

    function automatic t_cw cw_make(input logic emit, input t_src src,
                                    input logic is_data, input t_lastk lastk,
                                    input t_jmp jmp, input logic rd,
                                    input logic adv);
        t_cw w;
        w.emit    = emit;
        w.src     = src;
        w.is_data = is_data;
        w.lastk   = lastk;
        w.jmp     = jmp;
        w.rd      = rd;
        w.adv     = adv;
        return w;
    endfunction

    // control store
    function automatic t_cw ucode_word(input t_step a);
        t_cw w;
        unique case (a)
            ST_IDLE:  w = cw_make(1'b0, SRC_NONE,  1'b0, LAST_NO,  JMP_DISPATCH, 1'b0, 1'b0);
            ST_CASET: w = cw_make(1'b1, SRC_CASET, 1'b0, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_XH:    w = cw_make(1'b1, SRC_X_HI,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_XL:    w = cw_make(1'b1, SRC_X_LO,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_EH:    w = cw_make(1'b1, SRC_E_HI,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_EL:    w = cw_make(1'b1, SRC_E_LO,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_PASET: w = cw_make(1'b1, SRC_PASET, 1'b0, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_YH0:   w = cw_make(1'b1, SRC_Y_HI,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_YL0:   w = cw_make(1'b1, SRC_Y_LO,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_YH1:   w = cw_make(1'b1, SRC_Y_HI,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_YL1:   w = cw_make(1'b1, SRC_Y_LO,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_RAMWR: w = cw_make(1'b1, SRC_RAMWR, 1'b0, LAST_YES, JMP_IDLE,     1'b0, 1'b0);
            ST_PTEST: w = cw_make(1'b0, SRC_NONE,  1'b0, LAST_NO,  JMP_PTEST,    1'b1, 1'b0);
            ST_PIX0:  w = cw_make(1'b1, SRC_PIX0,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_PIX1:  w = cw_make(1'b1, SRC_PIX1,  1'b1, LAST_NO,  JMP_NEXT,     1'b0, 1'b0);
            ST_PIX2:  w = cw_make(1'b1, SRC_PIX2,  1'b1, LAST_PIX, JMP_PLOOP,    1'b1, 1'b1);
        endcase
        return w;
    endfunction

    // number of pixel slots in one data byte
    function automatic logic [3:0] slot_limit(input t_depth d);
        logic [3:0] r;
        unique case (d)
            DEPTH_1BPP: r = 4'd8;
            DEPTH_4BPP: r = 4'd2;
            DEPTH_8BPP: r = 4'd1;
            DEPTH_RSVD: r = 4'd0;
        endcase
        return r;
    endfunction

    // palette index held in a given slot, MSB-first
    function automatic logic [7:0] slot_index(input logic [7:0] b, input t_depth d,
                                              input logic [3:0] pos);
        logic [7:0] r;
        unique case (d)
            DEPTH_1BPP: r = {7'd0, b[~pos[2:0]]};
            DEPTH_4BPP: r = pos[0] ? {4'd0, b[3:0]} : {4'd0, b[7:4]};
            DEPTH_8BPP: r = b;
            DEPTH_RSVD: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/pplcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pplcd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pplcd_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
`include "palette_pixel_run_to_lcd_bus_unit_defines.svh"

module pplcd_seq
    import pplcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cond i_cond,
    output t_ctl  o_ctl
);

    t_step r_step;
    t_step n_step;
    t_cw   cw;
    logic  fire;

    assign cw   = ucode_word(r_step);
    // emitting steps wait for room in the output register
    assign fire = cw.emit ? i_cond.out_free : 1'b1;

    always_comb begin
        n_step = r_step;
        unique case (cw.jmp)
            JMP_NEXT: begin
                if (fire) n_step = r_step + 4'd1;
            end
            JMP_DISPATCH: begin
                priority if (i_cond.in_fire && i_cond.mode == MODE_START) n_step = ST_CASET;
                else if (i_cond.in_fire && i_cond.mode == MODE_DATA) n_step = ST_PTEST;
                else n_step = ST_IDLE;
            end
            JMP_PTEST: begin
                n_step = i_cond.pix_ok ? ST_PIX0 : ST_IDLE;
            end
            JMP_PLOOP: begin
                if (fire) n_step = i_cond.next_ok ? ST_PIX0 : ST_IDLE;
            end
            JMP_IDLE: begin
                if (fire) n_step = ST_IDLE;
            end
            default: n_step = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.cw   = cw;
    assign o_ctl.fire = fire;
    assign o_ctl.done = (cw.jmp == JMP_PTEST && !i_cond.pix_ok) ||
                        (cw.jmp == JMP_PLOOP && fire && !i_cond.next_ok);
    assign o_ctl.idle = (r_step == ST_IDLE);

    `PPLCD_ASSERT_NOW(a_fire_only_idle, i_cond.in_fire, r_step == ST_IDLE, "beat taken while busy")
    `PPLCD_ASSERT_NEXT(a_start_to_window, i_cond.in_fire && i_cond.mode == MODE_START, r_step == ST_CASET, "run start did not enter window program")
    `PPLCD_ASSERT_NEXT(a_stall_holds, !fire, $stable(r_step), "step moved during output stall")
    `PPLCD_ASSERT_NEXT(a_done_to_idle, o_ctl.done, r_step == ST_IDLE, "byte end did not return to idle")

endmodule

### hw/rtl/palette_pixel_run_to_lcd_bus_unit.sv
// Palette pixel run to LCD bus unit: a palette write puts nothing on the bus;
// a run start emits 11 window bytes and then returns to idle; a data byte
// emits three bytes per pixel, up to eight pixels for a full one-bpp byte.
// The microcoded step counter emits one bus byte per cycle into the output
// register, except while a bus byte is due and the output register is full
// and not taken, and reads the single palette port once per pixel, overlapped
// with the previous pixel's last byte. One input beat is worked on at a time;
// a new beat is taken while the last bus byte of the previous one still waits
// in the output stage.
module palette_pixel_run_to_lcd_bus_unit
    import pplcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // palette_index, palette_color, start_column, start_row, pixel_count,
    // depth_code, first_offset, data_byte, zero pad
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,   // mode
    // bus byte stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // bus_byte
    output logic                  m_axis_tuser,   // is_data
    output logic                  m_axis_tlast
);

    t_cond cond;
    t_ctl  ctl;

    logic [7:0]  in_pal_idx;
    logic [23:0] in_pal_color;
    logic [10:0] in_x;
    logic [10:0] in_y;
    logic [10:0] in_count;
    t_depth      in_depth;
    logic [2:0]  in_offset;
    logic [7:0]  in_byte;
    t_mode       in_mode;
    logic        in_fire;

    logic [10:0] r_end_col;
    logic [10:0] r_x;
    logic [10:0] r_y;
    logic [10:0] r_left;
    logic [3:0]  r_pos;
    t_depth      r_depth;
    logic [7:0]  r_byte;
    logic        r_pix_zero;

    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_ouser;
    logic        r_olast;

    logic [3:0]  limit;
    logic [3:0]  pos_next;
    logic        pix_ok;
    logic        next_ok;
    logic        out_free;
    logic        emit_fire;
    logic        cfg_wr;

    logic              pal_we;
    logic              pal_re;
    logic [7:0]        rd_idx;
    logic [23:0]       pal_rdata;
    logic [23:0]       color;
    logic [17:0]       c666;
    logic [7:0]        bus_byte;
    logic              bus_last;

    assign in_pal_idx   = s_axis_tdata[7:0];
    assign in_pal_color = s_axis_tdata[31:8];
    assign in_x         = s_axis_tdata[42:32];
    assign in_y         = s_axis_tdata[53:43];
    assign in_count     = s_axis_tdata[64:54];
    assign in_depth     = t_depth'(s_axis_tdata[66:65]);
    assign in_offset    = s_axis_tdata[69:67];
    assign in_byte      = s_axis_tdata[77:70];
    assign in_mode      = t_mode'(s_axis_tuser);

    assign s_axis_tready = ctl.idle;
    assign in_fire       = s_axis_tvalid & ctl.idle;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr == REG_END_COL);
    assign prdata = (paddr == REG_END_COL) ? {21'd0, r_end_col} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_col <= END_COL_RST;
        end else if (cfg_wr) begin
            r_end_col <= pwdata[10:0];
        end
    end

    // slot tests
    assign limit    = slot_limit(r_depth);
    assign pos_next = r_pos + 4'd1;
    assign pix_ok   = (r_pos < limit) && (r_left != 11'd0);
    assign next_ok  = (pos_next < limit) && (r_left != 11'd1);
    assign out_free = !r_ovalid || m_axis_tready;

    assign cond.in_fire  = in_fire;
    assign cond.mode     = in_mode;
    assign cond.pix_ok   = pix_ok;
    assign cond.next_ok  = next_ok;
    assign cond.out_free = out_free;

    pplcd_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cond (cond),
        .o_ctl  (ctl)
    );

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= 11'd0;
            r_pos   <= 4'd0;
            r_depth <= DEPTH_1BPP;
        end else begin
            if (in_fire && in_mode == MODE_START) begin
                r_left  <= in_count;
                r_depth <= in_depth;
                unique case (in_depth)
                    DEPTH_1BPP: r_pos <= {1'b0, in_offset};
                    DEPTH_4BPP: r_pos <= {3'd0, in_offset[0]};
                    default:    r_pos <= 4'd0;
                endcase
            end
            if (ctl.cw.adv && ctl.fire) begin
                r_left <= r_left - 11'd1;
                r_pos  <= pos_next;
            end
            // next data byte starts at its top slot
            if (ctl.done) begin
                r_pos <= 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && in_mode == MODE_START) begin
            r_x <= in_x & COORD_MASK;
            r_y <= in_y & COORD_MASK;
        end
        if (in_fire && in_mode == MODE_DATA) begin
            r_byte <= in_byte;
        end
        if (pal_re) begin
            r_pix_zero <= ({1'b0, rd_idx} >= PAL_LIMIT);
        end
    end

    // palette
    assign pal_we = in_fire && in_mode == MODE_PAL_WR && ({1'b0, in_pal_idx} < PAL_LIMIT);
    assign pal_re = ctl.cw.rd && ctl.fire;
    // the last byte of a pixel fetches the following slot
    assign rd_idx = slot_index(r_byte, r_depth, ctl.cw.adv ? pos_next : r_pos);

    pplcd_ram #(
        .WIDTH(24),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (pal_we),
        .i_waddr(in_pal_idx[PAL_AW-1:0]),
        .i_wdata(in_pal_color),
        .i_re   (pal_re),
        .i_raddr(rd_idx[PAL_AW-1:0]),
        .o_rdata(pal_rdata)
    );

    assign color = r_pix_zero ? 24'd0 : pal_rdata;
    assign c666  = {color[23:18], color[15:10], color[7:2]};

    always_comb begin
        unique case (ctl.cw.src)
            SRC_CASET: bus_byte = CMD_CASET;
            SRC_PASET: bus_byte = CMD_PASET;
            SRC_RAMWR: bus_byte = CMD_RAMWR;
            SRC_X_HI:  bus_byte = {5'd0, r_x[10:8]};
            SRC_X_LO:  bus_byte = r_x[7:0];
            SRC_E_HI:  bus_byte = {5'd0, r_end_col[10:8]};
            SRC_E_LO:  bus_byte = r_end_col[7:0];
            SRC_Y_HI:  bus_byte = {5'd0, r_y[10:8]};
            SRC_Y_LO:  bus_byte = r_y[7:0];
            SRC_PIX0:  bus_byte = c666[17:10];
            SRC_PIX1:  bus_byte = c666[11:4];
            SRC_PIX2:  bus_byte = {c666[5:0], 2'b00};
            default:   bus_byte = 8'd0;
        endcase
    end

    always_comb begin
        unique case (ctl.cw.lastk)
            LAST_YES: bus_last = 1'b1;
            LAST_PIX: bus_last = !next_ok;
            default:  bus_last = 1'b0;
        endcase
    end

    // output register
    assign emit_fire = ctl.cw.emit & ctl.fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_fire) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_obyte <= bus_byte;
            r_ouser <= ctl.cw.is_data;
            r_olast <= bus_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_obyte;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule
